// ===== hw/rtl/cfa_pkg.sv =====
package cfa_pkg;

	// widest crc the ports carry, in bits and bytes
	localparam int CRC_W      = 64;
	localparam int CRC_BYTES  = 8;
	localparam int COUNT_OUT_W = 32;

	// output tdata: out_byte, crc_ok, crc_value, failed_count, success_count, zero fill
	localparam int M_TDATA_W  = 144;
	localparam int M_TUSER_W  = 2;

	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_BYTES = 3'd1;
	localparam logic [2:0] REG_POLY  = 3'd2;
	localparam logic [2:0] REG_INIT  = 3'd3;
	localparam logic [2:0] REG_XOR   = 3'd4;

	// configuration reset values
	localparam logic        MODE_RST  = 1'b0;
	localparam logic [3:0]  BYTES_RST = 4'd4;
	localparam logic [63:0] POLY_RST  = 64'h0000_0000_04C1_1DB7;
	localparam logic [63:0] INIT_RST  = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] XOR_RST   = 64'h0000_0000_FFFF_FFFF;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_VERIFY = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [3:0]  len;        // clamped crc length in bytes
		logic [63:0] poly;
		logic [63:0] init;
		logic [63:0] xor_val;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_BYTE,         // one pass-through byte
		CMD_BYTE_CRC,     // last payload byte, then the crc bytes
		CMD_BYTE_STATUS,  // released tail byte, then verify status
		CMD_STATUS        // verify status only
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        clear;  // clear counters before this command's results
		logic        full;   // tail held a whole crc at frame end
		logic [63:0] crc;    // finished crc, masked to the crc width
		logic [63:0] tail;   // received crc bytes, oldest in the low byte
	} cmd_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        byte_valid;
		logic        frame_end;
		logic        run_last;
		logic        crc_ok;
		logic [63:0] crc_value;
		logic [31:0] failed;
		logic [31:0] success;
	} res_t;

	function automatic logic [7:0] bit_rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/crc_frame_append_verify.sv =====
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: data_byte; tlast: last_byte;
//                                                   tuser: clear_stats
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: out_byte .. success_count;
//                                                   tlast: frame_end; tuser: byte_valid, run_last
// cfg       in         cfg_wr_en (no wait)          cfg_index, cfg_data
//
// one input byte per cycle while the command queue has room; an append-mode frame end emits
// 1 + crc_bytes results, one per cycle while m_axis_tready is high, so the input can stall there
// results pass through the command queue entry and the back output register
// the two-entry command queue lets the input run while the output is stalled
// arst_n clears control state; configuration returns to crc-32 defaults
// a configuration write to a listed register restarts the frame, counters are kept
module crc_frame_append_verify
	import cfa_pkg::*;
#(
	parameter int MAX_CRC_BYTES = 8,
	parameter int COUNT_WIDTH   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	// input bytes
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
	input  logic                 s_axis_tlast,   // last_byte
	input  logic                 s_axis_tuser,   // [0] clear_stats
	// results
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [7:0] out_byte, [8] crc_ok, [72:9] crc_value, [104:73] failed_count,
	// [136:105] success_count, [143:137] zero
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tlast,   // frame_end
	output logic [M_TUSER_W-1:0] m_axis_tuser    // [0] byte_valid, [1] run_last
);

	// configuration registers
	logic        mode_q;
	logic [3:0]  bytes_q;
	logic [63:0] poly_q;
	logic [63:0] init_q;
	logic [63:0] xor_q;
	logic        restart;
	logic [3:0]  len_eff;
	cfg_t        cfg;

	// front to queue to back
	logic        push;
	cmd_t        push_cmd;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	cmd_t        q_head;
	res_t        res;

	// register write decode; an index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RST;
			bytes_q <= BYTES_RST;
			poly_q  <= POLY_RST;
			init_q  <= INIT_RST;
			xor_q   <= XOR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[0];
				REG_BYTES: bytes_q <= cfg_data[3:0];
				REG_POLY:  poly_q  <= cfg_data;
				REG_INIT:  init_q  <= cfg_data;
				REG_XOR:   xor_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign restart = cfg_wr_en && (cfg_index <= REG_XOR);

	// zero length acts as one byte, anything past the maximum as the maximum
	always_comb begin
		if (bytes_q == 4'd0) begin
			len_eff = 4'd1;
		end else if (bytes_q > 4'(MAX_CRC_BYTES)) begin
			len_eff = 4'(MAX_CRC_BYTES);
		end else begin
			len_eff = bytes_q;
		end
	end

	assign cfg.mode    = mode_q;
	assign cfg.len     = len_eff;
	assign cfg.poly    = poly_q;
	assign cfg.init    = init_q;
	assign cfg.xor_val = xor_q;

	// front: crc update, delay line, command classification
	cfa_front #(
		.MAX_CRC_BYTES (MAX_CRC_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.restart  (restart),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.in_clear (s_axis_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// command queue decouples the byte rate from result expansion
	cfa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	// back: crc byte expansion, verify compare, counters, output register
	cfa_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.crc_len   (len_eff),
		.empty     (q_empty),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {7'd0, res.success, res.failed, res.crc_value, res.crc_ok, res.data};
	assign m_axis_tlast = res.frame_end;
	assign m_axis_tuser = {res.run_last, res.byte_valid};

endmodule

// ===== hw/rtl/cfa_queue.sv =====
module cfa_queue
	import cfa_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	cmd_t            entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full  = (count_q == CNTW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hw/rtl/cfa_front.sv =====
module cfa_front
	import cfa_pkg::*;
#(
	parameter int MAX_CRC_BYTES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       restart,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_data,
	input  logic       in_last,
	input  logic       in_clear,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	localparam int CW = 8 * MAX_CRC_BYTES;
	localparam int NW = $clog2(MAX_CRC_BYTES + 1);

	logic [CW-1:0] crc_q;
	logic          fresh_q;  // crc register holds the reflected init value
	logic [CW-1:0] tail_q;
	logic [NW-1:0] fill_q;
	logic          pend_q;   // clear request from an item that made no command

	logic [CW-1:0] mask;
	logic [CW-1:0] rpoly;
	logic [CW-1:0] rinit;
	logic [CW-1:0] fxor;
	logic [CW-1:0] crc_eff;
	logic [CW-1:0] fed;
	logic [CW-1:0] crc_new;
	logic [CW-1:0] tail_n;
	logic [NW-1:0] wr_idx;
	logic [NW-1:0] fill_n;
	logic [7:0]    feed_byte;
	logic          pop_tail;
	logic          do_feed;
	logic          accept;

	// reflect over the crc width, byte by byte
	always_comb begin
		mask  = '0;
		rpoly = '0;
		rinit = '0;
		for (int j = 0; j < MAX_CRC_BYTES; j++) begin
			if (j < int'(cfg.len)) begin
				mask[8*j +: 8]  = 8'hFF;
				rpoly[8*j +: 8] = bit_rev8(cfg.poly[8*(int'(cfg.len) - 1 - j) +: 8]);
				rinit[8*j +: 8] = bit_rev8(cfg.init[8*(int'(cfg.len) - 1 - j) +: 8]);
			end
		end
		fxor = cfg.xor_val[CW-1:0] & mask;
	end

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign crc_eff   = fresh_q ? rinit : crc_q;
	assign pop_tail  = (cfg.mode == MODE_VERIFY) && (4'(fill_q) >= cfg.len);
	assign do_feed   = (cfg.mode == MODE_APPEND) || pop_tail;
	assign feed_byte = (cfg.mode == MODE_VERIFY) ? tail_q[7:0] : in_data;

	// eight-bit unrolled right-shifting update
	always_comb begin
		fed = crc_eff ^ CW'(feed_byte);
		for (int k = 0; k < 8; k++) begin
			fed = fed[0] ? ((fed >> 1) ^ rpoly) : (fed >> 1);
		end
	end

	assign crc_new = do_feed ? fed : crc_eff;

	// delay line: release the oldest byte once full, then append the new one
	assign wr_idx = pop_tail ? NW'(cfg.len - 4'd1) : fill_q;
	assign fill_n = wr_idx + 1'b1;

	always_comb begin
		tail_n = pop_tail ? (tail_q >> 8) : tail_q;
		for (int i = 0; i < MAX_CRC_BYTES; i++) begin
			if (wr_idx == NW'(i)) begin
				tail_n[8*i +: 8] = in_data;
			end
		end
	end

	always_comb begin
		push_cmd.data  = feed_byte;
		push_cmd.clear = in_clear | pend_q;
		push_cmd.full  = (4'(fill_n) >= cfg.len);
		push_cmd.crc   = CRC_W'(crc_new ^ fxor);
		push_cmd.tail  = CRC_W'(tail_n);
		if (cfg.mode == MODE_APPEND) begin
			push_cmd.kind = in_last ? CMD_BYTE_CRC : CMD_BYTE;
		end else if (pop_tail) begin
			push_cmd.kind = in_last ? CMD_BYTE_STATUS : CMD_BYTE;
		end else begin
			push_cmd.kind = CMD_STATUS;
		end
	end

	assign push = accept && ((cfg.mode == MODE_APPEND) || pop_tail || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			fill_q  <= '0;
			pend_q  <= 1'b0;
		end else if (restart) begin
			fresh_q <= 1'b1;
			fill_q  <= '0;
		end else if (accept) begin
			pend_q <= push ? 1'b0 : (pend_q | in_clear);
			if (in_last) begin
				fresh_q <= 1'b1;
				fill_q  <= '0;
			end else begin
				if (do_feed) begin
					fresh_q <= 1'b0;
				end
				if (cfg.mode == MODE_VERIFY) begin
					fill_q <= fill_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			crc_q  <= crc_new;
			tail_q <= tail_n;
		end
	end

endmodule

// ===== hw/rtl/cfa_back.sv =====
module cfa_back
	import cfa_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] crc_len,
	input  logic       empty,
	input  cmd_t       head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output res_t       out_res
);

	logic [3:0]             idx_q;  // result index within the head command
	logic [COUNT_WIDTH-1:0] frame_q;
	logic [COUNT_WIDTH-1:0] fail_q;
	logic                   out_valid_q;
	res_t                   res_q;

	logic                   load;
	logic                   take;
	logic                   is_stat;
	logic                   is_crcb;
	logic                   last_res;
	logic                   ok;
	logic [2:0]             sel;
	logic [63:0]            diff;
	logic [COUNT_WIDTH-1:0] frame_eff;
	logic [COUNT_WIDTH-1:0] fail_eff;
	logic [COUNT_WIDTH-1:0] frame_nx;
	logic [COUNT_WIDTH-1:0] fail_nx;
	logic [COUNT_WIDTH-1:0] success_nx;
	res_t                   res_d;

	assign load = !out_valid_q || out_ready;
	assign take = load && !empty;
	assign pop  = take && last_res;
	assign sel  = 3'(idx_q - 4'd1);

	always_comb begin
		is_stat  = 1'b0;
		is_crcb  = 1'b0;
		last_res = 1'b0;
		unique case (head.kind)
			CMD_BYTE: begin
				last_res = 1'b1;
			end
			CMD_BYTE_CRC: begin
				is_crcb  = (idx_q != 4'd0);
				last_res = (idx_q == crc_len);
			end
			CMD_BYTE_STATUS: begin
				is_stat  = (idx_q != 4'd0);
				last_res = (idx_q != 4'd0);
			end
			CMD_STATUS: begin
				is_stat  = 1'b1;
				last_res = 1'b1;
			end
			default: begin
				last_res = 1'b1;
			end
		endcase
	end

	// received bytes against the computed crc over the crc length
	assign diff = head.crc ^ head.tail;
	always_comb begin
		ok = head.full;
		for (int j = 0; j < CRC_BYTES; j++) begin
			if ((j < int'(crc_len)) && (diff[8*j +: 8] != 8'h00)) begin
				ok = 1'b0;
			end
		end
	end

	always_comb begin
		frame_eff = (head.clear && (idx_q == 4'd0)) ? '0 : frame_q;
		fail_eff  = (head.clear && (idx_q == 4'd0)) ? '0 : fail_q;
		frame_nx  = frame_eff;
		fail_nx   = fail_eff;
		if (is_stat) begin
			frame_nx = frame_eff + 1'b1;
			if (frame_nx == '0) begin
				fail_nx = '0;
			end else if (!ok) begin
				fail_nx = fail_eff + 1'b1;
			end
		end
		success_nx = frame_nx - fail_nx;
	end

	always_comb begin
		res_d.byte_valid = !is_stat;
		res_d.frame_end  = is_stat || (is_crcb && (idx_q == crc_len));
		res_d.run_last   = last_res;
		res_d.crc_ok     = is_stat && ok;
		res_d.crc_value  = res_d.frame_end ? head.crc : '0;
		res_d.failed     = COUNT_OUT_W'(fail_nx);
		res_d.success    = COUNT_OUT_W'(success_nx);
		if (is_stat) begin
			res_d.data = 8'h00;
		end else if (is_crcb) begin
			res_d.data = head.crc[8*sel +: 8];
		end else begin
			res_d.data = head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			frame_q     <= '0;
			fail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !empty;
			end
			if (take) begin
				idx_q   <= last_res ? 4'd0 : idx_q + 4'd1;
				frame_q <= frame_nx;
				fail_q  <= fail_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

// ===== hw/rtl/cfa_check.sv =====
module cfa_check
	import cfa_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_wr_en,
	input logic [2:0]           cfg_index,
	input logic [63:0]          cfg_data,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [7:0]           s_axis_tdata,
	input logic                 s_axis_tlast,
	input logic                 s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tlast,
	input logic [M_TUSER_W-1:0] m_axis_tuser
);

	// a frame end is always the final result of its input transaction
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
		else $error("frame end not marked as last result");

	// crc_ok only on a status result, which carries no frame byte
	a_ok_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tlast && !m_axis_tuser[0])
		else $error("crc_ok outside a status result");

	// crc value shows only at frame end
	a_crc_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[72:9] == 64'd0)
		else $error("crc value on a mid-frame result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind crc_frame_append_verify cfa_check u_cfa_check (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import cfa_pkg::*;

	// margin after the last expected result: two pipeline stages plus slack
	localparam int SETTLE_CYCLES = 6;
	// worst case is far below this: ~150 items, 9 results each, stalls on both sides
	localparam int CYCLE_LIMIT   = 500000;
	localparam int REPORT_MAX    = 10;
	localparam int RANDOM_ITEMS  = 80;

	typedef logic [7:0] byte_q_t[$];

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 cfg_wr_en     = 1'b0;
	logic [2:0]           cfg_index     = '0;
	logic [63:0]          cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = '0;
	logic                 s_axis_tlast  = 1'b0;
	logic                 s_axis_tuser  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tlast;
	logic [M_TUSER_W-1:0] m_axis_tuser;

	// run bookkeeping
	int items_sent  = 0;
	int err_total   = 0;
	int cycle_cnt   = 0;
	int sink_gap    = 0;
	bit src_gaps    = 1'b1;
	bit sink_stalls = 1'b1;

	// predictor copy of the configuration registers
	logic        set_mode;
	logic [3:0]  set_len;
	logic [63:0] set_poly;
	logic [63:0] set_init;
	logic [63:0] set_xor;

	// predictor copy of the datapath state
	logic [63:0] crc_acc;
	logic [7:0]  tail_buf [CRC_BYTES];
	int          tail_cnt;
	logic [31:0] frames_seen;
	logic [31:0] frames_failed;

	// expected output transactions, oldest first
	res_t expected_q[$];

	crc_frame_append_verify u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// crc predictor
	// ------------------------------------------------------------------

	// crc length in bytes after clamping zero up and large values down
	function automatic int crc_len();
		if (set_len == 4'd0) return 1;
		if (set_len > CRC_BYTES) return CRC_BYTES;
		return int'(set_len);
	endfunction

	function automatic logic [63:0] len_mask(input int n);
		return (n >= 8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
	endfunction

	function automatic logic [63:0] mirror(input logic [63:0] v, input int bits);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < bits; i++) begin
			if (v[i]) r[bits - 1 - i] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [63:0] crc_seed();
		return mirror(set_init & len_mask(crc_len()), 8 * crc_len());
	endfunction

	// one byte through the reflected, right-shifting register
	function automatic logic [63:0] crc_shift(input logic [63:0] acc_in, input logic [7:0] b);
		logic [63:0] acc;
		logic [63:0] rpoly;
		rpoly = mirror(set_poly & len_mask(crc_len()), 8 * crc_len());
		acc   = acc_in ^ {56'd0, b};
		for (int k = 0; k < 8; k++) begin
			acc = acc[0] ? ((acc >> 1) ^ rpoly) : (acc >> 1);
		end
		return acc & len_mask(crc_len());
	endfunction

	function automatic logic [63:0] crc_finish(input logic [63:0] acc);
		return (acc ^ set_xor) & len_mask(crc_len());
	endfunction

	// crc of a whole payload under the current settings, state untouched
	function automatic logic [63:0] payload_crc(input byte_q_t p);
		logic [63:0] acc;
		acc = crc_seed();
		foreach (p[i]) acc = crc_shift(acc, p[i]);
		return crc_finish(acc);
	endfunction

	function automatic void crc_restart();
		crc_acc  = crc_seed();
		tail_cnt = 0;
		foreach (tail_buf[i]) tail_buf[i] = 8'd0;
	endfunction

	function automatic void model_reset();
		set_mode      = MODE_RST;
		set_len       = BYTES_RST;
		set_poly      = POLY_RST;
		set_init      = INIT_RST;
		set_xor       = XOR_RST;
		frames_seen   = '0;
		frames_failed = '0;
		crc_restart();
	endfunction

	// unlisted indexes are dropped and leave the open frame alone
	function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] val);
		case (idx)
			REG_MODE:  set_mode = val[0];
			REG_BYTES: set_len  = val[3:0];
			REG_POLY:  set_poly = val;
			REG_INIT:  set_init = val;
			REG_XOR:   set_xor  = val;
			default:   return;
		endcase
		crc_restart();
	endfunction

	// one result with the counters as they stand now
	function automatic res_t make_res(input logic [7:0] ob, input logic vld, input logic fend,
			input logic ok, input logic [63:0] cv);
		res_t r;
		r.data       = ob;
		r.byte_valid = vld;
		r.frame_end  = fend;
		r.run_last   = 1'b0;
		r.crc_ok     = ok;
		r.crc_value  = cv;
		r.failed     = frames_failed;
		r.success    = frames_seen - frames_failed;
		return r;
	endfunction

	// expected output transactions caused by one accepted input byte
	function automatic void predict_item(input logic [7:0] b, input logic last, input logic clr);
		res_t        batch[$];
		int          n;
		logic [63:0] c;
		logic        ok;
		logic [7:0]  old;
		n = crc_len();
		if (clr) begin
			frames_seen   = '0;
			frames_failed = '0;
		end
		if (set_mode == MODE_APPEND) begin
			crc_acc = crc_shift(crc_acc, b);
			batch.push_back(make_res(b, 1'b1, 1'b0, 1'b0, 64'd0));
			if (last) begin
				// crc follows the last byte, low byte first
				c = crc_finish(crc_acc);
				for (int i = 0; i < n; i++) begin
					batch.push_back(make_res(c[8 * i +: 8], 1'b1, i == n - 1, 1'b0,
						(i == n - 1) ? c : 64'd0));
				end
				crc_restart();
			end
		end else begin
			// full delay line: the oldest held byte becomes payload
			if (tail_cnt >= n) begin
				old = tail_buf[0];
				for (int i = 0; i < CRC_BYTES - 1; i++) tail_buf[i] = tail_buf[i + 1];
				tail_buf[CRC_BYTES - 1] = 8'd0;
				tail_cnt = n - 1;
				crc_acc  = crc_shift(crc_acc, old);
				batch.push_back(make_res(old, 1'b1, 1'b0, 1'b0, 64'd0));
			end
			tail_buf[tail_cnt] = b;
			tail_cnt++;
			if (last) begin
				// a frame shorter than the crc fails outright
				c  = crc_finish(crc_acc);
				ok = (tail_cnt >= n);
				for (int i = 0; i < n; i++) begin
					if (tail_buf[i] != c[8 * i +: 8]) ok = 1'b0;
				end
				frames_seen++;
				if (frames_seen == 32'd0) frames_failed = '0;
				else if (!ok) frames_failed++;
				batch.push_back(make_res(8'd0, 1'b0, 1'b1, ok, c));
				crc_restart();
			end
		end
		if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
		foreach (batch[i]) expected_q.push_back(batch[i]);
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one input transaction; tvalid stays high so back-to-back bytes flow
	task automatic send_byte(input logic [7:0] b, input logic last, input logic clr);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		s_axis_tuser  <= clr;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_item(b, last, clr);
		items_sent++;
	endtask

	// counter clear rides on byte clr_at, none when negative
	task automatic send_frame(input byte_q_t bytes, input int clr_at);
		foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, i == clr_at);
	endtask

	task automatic add_fcs(ref byte_q_t fr);
		logic [63:0] c;
		c = payload_crc(fr);
		for (int i = 0; i < crc_len(); i++) fr.push_back(c[8 * i +: 8]);
	endtask

	// stop sending and let every outstanding result drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes only happen with the block drained
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		apply_reg(idx, val);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// crc-32 defaults straight out of reset, data byte extremes
	task automatic test_append();
		byte_q_t fr;
		fr = {8'h00, 8'hFF};
		send_frame(fr, -1);
		fr = {8'h5A};
		send_frame(fr, 0);
	endtask

	// good frame, crc over an empty payload, frame shorter than the crc
	task automatic test_verify();
		byte_q_t fr;
		write_reg(REG_MODE, {63'd0, MODE_VERIFY});
		fr = {8'hA5};
		add_fcs(fr);
		send_frame(fr, -1);
		fr = {};
		add_fcs(fr);
		send_frame(fr, -1);
		fr = {8'hFF, 8'h00};
		send_frame(fr, 1);
	endtask

	// length clamping and all-zero / all-one polynomial, init and xor
	task automatic test_crc_length();
		byte_q_t fr;
		write_reg(REG_BYTES, 64'd0);
		fr = {8'h3C};
		add_fcs(fr);
		send_frame(fr, -1);
		write_reg(REG_MODE, {63'd0, MODE_APPEND});
		write_reg(REG_BYTES, 64'd15);
		write_reg(REG_POLY, {64{1'b1}});
		write_reg(REG_INIT, 64'd0);
		write_reg(REG_XOR, 64'd0);
		fr = {8'hFF};
		send_frame(fr, -1);
		write_reg(REG_BYTES, 64'd9);
		write_reg(REG_POLY, 64'd0);
		write_reg(REG_INIT, {64{1'b1}});
		write_reg(REG_XOR, {64{1'b1}});
		fr = {8'h81};
		send_frame(fr, -1);
		write_reg(REG_BYTES, 64'd1);
		fr = {8'h00};
		send_frame(fr, -1);
	endtask

	// writes in the middle of a frame
	task automatic test_config_restart();
		write_reg(REG_MODE, {63'd0, MODE_VERIFY});
		write_reg(REG_BYTES, 64'd2);
		write_reg(REG_POLY, POLY_RST);
		write_reg(REG_INIT, INIT_RST);
		write_reg(REG_XOR, XOR_RST);
		// two bytes sit in the delay line, then the write throws them away
		send_byte(8'h11, 1'b0, 1'b0);
		send_byte(8'h22, 1'b0, 1'b0);
		write_reg(REG_POLY, POLY_RST);
		send_byte(8'h33, 1'b1, 1'b0);
		// unlisted indexes must not restart the open append frame
		write_reg(REG_MODE, {63'd0, MODE_APPEND});
		send_byte(8'h44, 1'b0, 1'b0);
		for (int k = REG_XOR + 1; k < 8; k++) write_reg(3'(k), rand64());
		send_byte(8'h55, 1'b1, 1'b0);
		// append restart mid-frame, crc starts over from the new init
		send_byte(8'h66, 1'b0, 1'b0);
		write_reg(REG_INIT, rand64());
		send_byte(8'h77, 1'b1, 1'b1);
	endtask

	// random settings between phases, each write only with the block drained
	task automatic new_setting();
		logic [63:0] v;
		int          r;
		if ($urandom_range(0, 2) != 0) write_reg(REG_MODE, rand64());
		if ($urandom_range(0, 1) == 0) begin
			// mostly short crcs, now and then the clamped ends
			r = $urandom_range(0, 9);
			v = rand64();
			if (r < 6)       v[3:0] = 4'($urandom_range(1, 4));
			else if (r < 8)  v[3:0] = 4'($urandom_range(5, 8));
			else if (r == 8) v[3:0] = 4'd0;
			else             v[3:0] = 4'($urandom_range(9, 15));
			write_reg(REG_BYTES, v);
		end
		if ($urandom_range(0, 1) == 0) write_reg(REG_POLY, rand64());
		if ($urandom_range(0, 2) == 0) write_reg(REG_INIT, rand64());
		if ($urandom_range(0, 2) == 0) write_reg(REG_XOR, rand64());
		if ($urandom_range(0, 5) == 0) write_reg(3'($urandom_range(REG_XOR + 1, 7)), rand64());
	endtask

	// mostly well-formed verify frames with random payloads, plus noise
	task automatic test_random();
		int      goal;
		int      plen;
		int      pos;
		byte_q_t fr;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			new_setting();
			repeat ($urandom_range(2, 5)) begin
				fr = {};
				if (set_mode == MODE_VERIFY && $urandom_range(0, 9) < 7) begin
					plen = $urandom_range(0, 5);
					repeat (plen) fr.push_back(8'($urandom));
					add_fcs(fr);
					// sometimes a single flipped bit somewhere in the frame
					if ($urandom_range(0, 5) == 0) begin
						pos     = $urandom_range(0, fr.size() - 1);
						fr[pos] = fr[pos] ^ (8'd1 << $urandom_range(0, 7));
					end
				end else begin
					plen = $urandom_range(1, 8);
					repeat (plen) fr.push_back(8'($urandom));
				end
				if ($urandom_range(0, 9) == 0) send_frame(fr, $urandom_range(0, fr.size() - 1));
				else send_frame(fr, -1);
			end
		end
	endtask

	// closing stretch with both sides at full rate
	task automatic test_back_to_back();
		byte_q_t fr;
		write_reg(REG_MODE, {63'd0, MODE_VERIFY});
		repeat (3) begin
			fr = {8'($urandom), 8'($urandom)};
			add_fcs(fr);
			send_frame(fr, -1);
		end
		write_reg(REG_MODE, {63'd0, MODE_APPEND});
		repeat (2) begin
			fr = {8'($urandom), 8'($urandom), 8'($urandom)};
			send_frame(fr, -1);
		end
	endtask

	// ------------------------------------------------------------------
	// result checking and sink-side stalls
	// ------------------------------------------------------------------

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.data       = m_axis_tdata[7:0];
			got.crc_ok     = m_axis_tdata[8];
			got.crc_value  = m_axis_tdata[72:9];
			got.failed     = m_axis_tdata[104:73];
			got.success    = m_axis_tdata[136:105];
			got.frame_end  = m_axis_tlast;
			got.byte_valid = m_axis_tuser[0];
			got.run_last   = m_axis_tuser[1];
			if (expected_q.size() == 0) begin
				err_total++;
				if (err_total <= REPORT_MAX)
					$display("unexpected transaction: data %h vld %b end %b last %b ok %b crc %h",
						got.data, got.byte_valid, got.frame_end, got.run_last, got.crc_ok,
						got.crc_value);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					err_total++;
					if (err_total <= REPORT_MAX) begin
						$display("mismatch exp: data %h vld %b end %b last %b ok %b crc %h fail %0d ok# %0d",
							want.data, want.byte_valid, want.frame_end, want.run_last,
							want.crc_ok, want.crc_value, want.failed, want.success);
						$display("         got: data %h vld %b end %b last %b ok %b crc %h fail %0d ok# %0d",
							got.data, got.byte_valid, got.frame_end, got.run_last,
							got.crc_ok, got.crc_value, got.failed, got.success);
					end
				end
			end
		end
		// ready drops in bursts of random length
		if (sink_gap > 0) sink_gap--;
		else if (sink_stalls && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 18);
		m_axis_tready <= (sink_gap == 0);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d transactions outstanding",
				cycle_cnt, expected_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		model_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_append();
		test_verify();
		test_crc_length();
		test_config_restart();
		test_random();
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		test_back_to_back();
		settle();
		if (err_total == 0 && expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
